### hw/rtl/aarm_pkg.sv
// Shared types and constants for the axis-angle to rotation matrix block.
// It depends on nothing; the channel interfaces and the top level import it.
`default_nettype none

package aarm_pkg;

    typedef logic signed [15:0] word_t;

    localparam int FRAC_BITS_DEF = 14;

    // Fixed-point constants of the sine and versine evaluation, all in Q30.
    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam int          HORNER_STEPS = 6;

    // Divisors of the nested series for sine.
    function automatic logic [7:0] sin_div(input logic [2:0] idx);
        logic [7:0] d;
        begin
            unique case (idx)
                3'd0:    d = 8'd156;
                3'd1:    d = 8'd110;
                3'd2:    d = 8'd72;
                3'd3:    d = 8'd42;
                3'd4:    d = 8'd20;
                default: d = 8'd6;
            endcase
            return d;
        end
    endfunction

    // Divisors of the nested series for one minus cosine.
    function automatic logic [7:0] vers_div(input logic [2:0] idx);
        logic [7:0] d;
        begin
            unique case (idx)
                3'd0:    d = 8'd182;
                3'd1:    d = 8'd132;
                3'd2:    d = 8'd90;
                3'd3:    d = 8'd56;
                3'd4:    d = 8'd30;
                default: d = 8'd12;
            endcase
            return d;
        end
    endfunction

    // floor(2^32 / divisor) for the sine series.
    function automatic logic [29:0] sin_recip(input logic [2:0] idx);
        logic [29:0] m;
        begin
            unique case (idx)
                3'd0:    m = 30'd27531841;
                3'd1:    m = 30'd39045157;
                3'd2:    m = 30'd59652323;
                3'd3:    m = 30'd102261126;
                3'd4:    m = 30'd214748364;
                default: m = 30'd715827882;
            endcase
            return m;
        end
    endfunction

    // floor(2^32 / divisor) for the versine series.
    function automatic logic [29:0] vers_recip(input logic [2:0] idx);
        logic [29:0] m;
        begin
            unique case (idx)
                3'd0:    m = 30'd23598721;
                3'd1:    m = 30'd32537631;
                3'd2:    m = 30'd47721858;
                3'd3:    m = 30'd76695844;
                3'd4:    m = 30'd143165576;
                default: m = 30'd357913941;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/aarm_if.sv
// Valid/ready channel interfaces for the axis-angle input item and the matrix result item.
// Depends on aarm_pkg for the word type.
`default_nettype none

interface aarm_pose_if
    import aarm_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t axis_x;
    word_t axis_y;
    word_t axis_z;
    word_t angle;

    modport source (output valid, output axis_x, output axis_y, output axis_z,
                    output angle, input ready);
    modport sink   (input valid, input axis_x, input axis_y, input axis_z,
                    input angle, output ready);
endinterface

interface aarm_matrix_if
    import aarm_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t m00;
    word_t m01;
    word_t m02;
    word_t m10;
    word_t m11;
    word_t m12;
    word_t m20;
    word_t m21;
    word_t m22;

    modport source (output valid, output m00, output m01, output m02, output m10,
                    output m11, output m12, output m20, output m21, output m22,
                    input ready);
    modport sink   (input valid, input m00, input m01, input m02, input m10,
                    input m11, input m12, input m20, input m21, input m22,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/axis_angle_to_rotation_matrix_top.sv
// Axis-angle to rotation matrix (Rodrigues formula) as a 25-stage pipeline.
// Depends on aarm_pkg and the channel interfaces in aarm_if.sv.
`default_nettype none

// The block takes one item per cycle on the pose channel unless it is stalled: a rotation
// axis in signed Q1.FRAC_BITS and a 16-bit binary angle (32768 is pi, the angle wraps).
// Each item gives exactly one result item on the matrix channel, the nine entries of the
// rotation matrix in row-major order, signed Q1.FRAC_BITS and saturated to 16 bits. The
// axis is used as given, without normalization. The block is a 25-stage pipeline with no
// state between items, and while the output side takes every result the sustained rate
// is one item per cycle. The first two stages turn the angle remainder into radians and
// square it; eighteen stages evaluate the nested sine and versine series, three stages
// per term (multiply, reciprocal multiply for the constant divisor, remainder correction);
// the last five finish the first-quadrant sine and versine, fold in the quadrant, form
// the axis products, round them and sum and saturate the entries. The last stage is the
// output register. When a result waits there and is not taken, the whole pipeline holds
// and the pose channel drops ready; nothing is lost or repeated.
module axis_angle_to_rotation_matrix_top
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    aarm_pose_if.sink     pose,
    aarm_matrix_if.source matrix
);

    localparam int NS  = 25;
    localparam int PSH = FRAC_BITS + 30;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [1:0]         quad;
        logic [13:0]        r;
        logic [30:0]        theta;
        logic [31:0]        t2;
        logic [30:0]        hs;
        logic [30:0]        hc;
        logic [31:0]        xs;
        logic [31:0]        xc;
        logic [31:0]        qs;
        logic [31:0]        qc;
        logic [31:0]        s1;
        logic [31:0]        v1;
        logic signed [31:0] s;
        logic [31:0]        v;
        logic [5:0][31:0]   pa;
        logic [2:0][46:0]   usa;
        logic [2:0]         nsa;
        logic [5:0][39:0]   ra;
        logic [2:0][39:0]   rsa;
        logic [8:0][15:0]   m;
    } stage_t;

    stage_t     pipe_reg  [NS];
    stage_t     pipe_next [NS];
    stage_t     stage_src [NS];
    logic [NS-1:0] vld_reg;
    logic       stall;
    stage_t     entry;

    // Angle remainder to radians in Q30, rounded.
    function automatic stage_t f_theta(input stage_t p);
        stage_t      o;
        logic [44:0] pr;
        begin
            o  = p;
            pr = 45'(p.r) * 45'(HALF_PI_Q30) + 45'd8192;
            o.theta = 31'(pr >> 14);
            return o;
        end
    endfunction

    function automatic stage_t f_square(input stage_t p);
        stage_t      o;
        logic [61:0] sq;
        begin
            o  = p;
            sq = 62'(p.theta) * 62'(p.theta) + 62'(Q30_ONE >> 1);
            o.t2 = 32'(sq >> 30);
            o.hs = Q30_ONE;
            o.hc = Q30_ONE;
            return o;
        end
    endfunction

    function automatic stage_t f_hmul(input stage_t p);
        stage_t      o;
        logic [62:0] ps;
        logic [62:0] pc;
        begin
            o  = p;
            ps = 63'(p.t2) * 63'(p.hs) + 63'(Q30_ONE >> 1);
            pc = 63'(p.t2) * 63'(p.hc) + 63'(Q30_ONE >> 1);
            o.xs = 32'(ps >> 30);
            o.xc = 32'(pc >> 30);
            return o;
        end
    endfunction

    // Quotient estimate by reciprocal; it is exact or one short.
    function automatic stage_t f_hrecip(input stage_t p, input logic [2:0] j);
        stage_t      o;
        logic [63:0] es;
        logic [63:0] ec;
        begin
            o  = p;
            es = 64'(p.xs) * 64'(sin_recip(j));
            ec = 64'(p.xc) * 64'(vers_recip(j));
            o.qs = 32'(es >> 32);
            o.qc = 32'(ec >> 32);
            return o;
        end
    endfunction

    function automatic stage_t f_hfix(input stage_t p, input logic [2:0] j);
        stage_t      o;
        logic [31:0] rs;
        logic [31:0] rc;
        logic [31:0] qs;
        logic [31:0] qc;
        begin
            o  = p;
            rs = p.xs - 32'(p.qs * 32'(sin_div(j)));
            rc = p.xc - 32'(p.qc * 32'(vers_div(j)));
            qs = (rs >= 32'(sin_div(j)))  ? p.qs + 32'd1 : p.qs;
            qc = (rc >= 32'(vers_div(j))) ? p.qc + 32'd1 : p.qc;
            o.hs = 31'(32'(Q30_ONE) - qs);
            o.hc = 31'(32'(Q30_ONE) - qc);
            return o;
        end
    endfunction

    // First-quadrant sine and versine, clamped to one.
    function automatic stage_t f_final(input stage_t p);
        stage_t      o;
        logic [61:0] ps;
        logic [62:0] pv;
        logic [31:0] s1;
        logic [31:0] v1;
        begin
            o  = p;
            ps = 62'(p.theta) * 62'(p.hs) + 62'(Q30_ONE >> 1);
            pv = 63'(p.t2) * 63'(p.hc) + 63'(Q30_ONE >> 1);
            s1 = 32'(ps >> 30);
            v1 = 32'(pv >> 31);
            o.s1 = (s1 > 32'(Q30_ONE)) ? 32'(Q30_ONE) : s1;
            o.v1 = (v1 > 32'(Q30_ONE)) ? 32'(Q30_ONE) : v1;
            return o;
        end
    endfunction

    function automatic stage_t f_quad(input stage_t p);
        stage_t             o;
        logic signed [31:0] c1;
        logic signed [31:0] s1;
        logic signed [31:0] cc;
        logic signed [32:0] vv;
        begin
            o  = p;
            s1 = $signed(p.s1);
            c1 = $signed(32'(Q30_ONE) - p.v1);
            case (p.quad)
                2'd0:    begin o.s = s1;  cc = c1;  end
                2'd1:    begin o.s = c1;  cc = -s1; end
                2'd2:    begin o.s = -s1; cc = -c1; end
                default: begin o.s = -c1; cc = s1;  end
            endcase
            vv  = $signed(33'(Q30_ONE)) - 33'(cc);
            o.v = 32'(vv);
            return o;
        end
    endfunction

    function automatic logic [15:0] mag16(input logic signed [15:0] a);
        begin
            return a[15] ? 16'(-a) : 16'(a);
        end
    endfunction

    // Axis pair products in order xx, yy, zz, xy, yz, zx; axis times sine magnitudes.
    function automatic stage_t f_prod(input stage_t p);
        stage_t             o;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        ms;
        begin
            o = p;
            x = 32'($signed(p.ax));
            y = 32'($signed(p.ay));
            z = 32'($signed(p.az));
            o.pa[0] = x * x;
            o.pa[1] = y * y;
            o.pa[2] = z * z;
            o.pa[3] = x * y;
            o.pa[4] = y * z;
            o.pa[5] = z * x;
            ms = p.s[31] ? 31'(-p.s) : 31'(p.s);
            o.usa[0] = 47'(mag16(p.ax)) * 47'(ms);
            o.usa[1] = 47'(mag16(p.ay)) * 47'(ms);
            o.usa[2] = 47'(mag16(p.az)) * 47'(ms);
            o.nsa[0] = p.ax[15] ^ p.s[31];
            o.nsa[1] = p.ay[15] ^ p.s[31];
            o.nsa[2] = p.az[15] ^ p.s[31];
            return o;
        end
    endfunction

    // Pair products times versine; all products round to nearest, ties away from zero.
    function automatic stage_t f_round(input stage_t p);
        stage_t      o;
        logic [30:0] mp;
        logic [62:0] pr;
        logic [39:0] t;
        logic [46:0] us;
        begin
            o = p;
            for (int i = 0; i < 6; i++)
            begin
                mp = p.pa[i][31] ? 31'(-p.pa[i]) : 31'(p.pa[i]);
                pr = 63'(mp) * 63'(p.v) + (63'(1) << (PSH - 1));
                t  = 40'(pr >> PSH);
                o.ra[i] = p.pa[i][31] ? -t : t;
            end
            for (int i = 0; i < 3; i++)
            begin
                us = p.usa[i] + (47'(1) << 29);
                t  = 40'(us >> 30);
                o.rsa[i] = p.nsa[i] ? -t : t;
            end
            return o;
        end
    endfunction

    function automatic logic [15:0] sat16(input logic signed [39:0] x);
        begin
            if (x > 40'sd32767)
                return 16'h7fff;
            else if (x < -40'sd32768)
                return 16'h8000;
            else
                return 16'(x);
        end
    endfunction

    function automatic stage_t f_out(input stage_t p);
        stage_t             o;
        logic signed [39:0] one;
        logic signed [39:0] xx, yy, zz, xy, yz, zx, sx, sy, sz;
        begin
            o   = p;
            one = 40'sd1 <<< FRAC_BITS;
            xx = $signed(p.ra[0]);
            yy = $signed(p.ra[1]);
            zz = $signed(p.ra[2]);
            xy = $signed(p.ra[3]);
            yz = $signed(p.ra[4]);
            zx = $signed(p.ra[5]);
            sx = $signed(p.rsa[0]);
            sy = $signed(p.rsa[1]);
            sz = $signed(p.rsa[2]);
            o.m[0] = sat16(one - zz - yy);
            o.m[1] = sat16(xy - sz);
            o.m[2] = sat16(sy + zx);
            o.m[3] = sat16(sz + xy);
            o.m[4] = sat16(one - zz - xx);
            o.m[5] = sat16(yz - sx);
            o.m[6] = sat16(zx - sy);
            o.m[7] = sat16(sx + yz);
            o.m[8] = sat16(one - yy - xx);
            return o;
        end
    endfunction

    always_comb
    begin
        entry      = '0;
        entry.ax   = pose.axis_x;
        entry.ay   = pose.axis_y;
        entry.az   = pose.axis_z;
        entry.quad = pose.angle[15:14];
        entry.r    = pose.angle[13:0];
    end

    // A result held in the output register freezes every stage.
    assign stall      = vld_reg[NS-1] && !matrix.ready;
    assign pose.ready = !stall;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        if (k == 0)
        begin : g_src0
            assign stage_src[k] = entry;
        end
        else
        begin : g_srcn
            assign stage_src[k] = pipe_reg[k-1];
        end

        if (k == 0)
        begin : g_theta
            assign pipe_next[k] = f_theta(stage_src[k]);
        end
        else if (k == 1)
        begin : g_square
            assign pipe_next[k] = f_square(stage_src[k]);
        end
        else if (k < 2 + 3 * HORNER_STEPS)
        begin : g_horner
            localparam int J  = (k - 2) / 3;
            localparam int PH = (k - 2) % 3;
            if (PH == 0)
            begin : g_mul
                assign pipe_next[k] = f_hmul(stage_src[k]);
            end
            else if (PH == 1)
            begin : g_recip
                assign pipe_next[k] = f_hrecip(stage_src[k], 3'(J));
            end
            else
            begin : g_fix
                assign pipe_next[k] = f_hfix(stage_src[k], 3'(J));
            end
        end
        else if (k == 20)
        begin : g_final
            assign pipe_next[k] = f_final(stage_src[k]);
        end
        else if (k == 21)
        begin : g_quad
            assign pipe_next[k] = f_quad(stage_src[k]);
        end
        else if (k == 22)
        begin : g_prod
            assign pipe_next[k] = f_prod(stage_src[k]);
        end
        else if (k == 23)
        begin : g_round
            assign pipe_next[k] = f_round(stage_src[k]);
        end
        else
        begin : g_out
            assign pipe_next[k] = f_out(stage_src[k]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (!stall)
                vld_reg[k] <= (k == 0) ? pose.valid : vld_reg[(k == 0) ? 0 : k - 1];
        end

        always_ff @(posedge clk)
        begin
            if (!stall)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    assign matrix.valid = vld_reg[NS-1];
    assign matrix.m00   = pipe_reg[NS-1].m[0];
    assign matrix.m01   = pipe_reg[NS-1].m[1];
    assign matrix.m02   = pipe_reg[NS-1].m[2];
    assign matrix.m10   = pipe_reg[NS-1].m[3];
    assign matrix.m11   = pipe_reg[NS-1].m[4];
    assign matrix.m12   = pipe_reg[NS-1].m[5];
    assign matrix.m20   = pipe_reg[NS-1].m[6];
    assign matrix.m21   = pipe_reg[NS-1].m[7];
    assign matrix.m22   = pipe_reg[NS-1].m[8];

    // With the output register empty the pipeline can never hold back an item.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NS-1] |-> pose.ready)
        else $error("pose channel not ready with an empty output register");

    // The corrected first series term never exceeds one.
    a_horner_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (pipe_reg[4].hs <= Q30_ONE && pipe_reg[4].hc <= Q30_ONE))
        else $error("series term out of range after correction");

    // After quadrant folding the sine stays within one and the versine within two.
    a_quadrant_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[21] |-> (pipe_reg[21].s <= 32'sd1073741824
                         && pipe_reg[21].s >= -32'sd1073741824
                         && pipe_reg[21].v <= 32'd2147483648))
        else $error("sine or versine out of range");

    // A stalled result keeps its entries until it is taken.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (vld_reg[NS-1] && $stable(pipe_reg[NS-1].m)))
        else $error("output register changed during a stall");

endmodule

`default_nettype wire
